### rtl/lgs_pkg.sv
package lgs_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 24;
   localparam int CENTER_W = 13;
   localparam int GRAD_W = 24;
   localparam int COLOR_W = 24;
   localparam int FRAME_W = 13;
   localparam int CHAN_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_X   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_Y   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_W  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_H  = CSR_IDX_W'(7);

   // 2*coord - center_sum, signed
   localparam int TWO_X_W = COORD_BITS + 1;
   localparam int DX_W = ((TWO_X_W > CENTER_W) ? TWO_X_W : CENTER_W) + 1;
   localparam int PROD_W = DX_W + GRAD_W;
   // twice the distance, FRAC_BITS fraction bits
   localparam int DIST_W = PROD_W + 1;
   // distance times an unsigned channel delta
   localparam int CH_PROD_W = DIST_W + CHAN_W + 1;
   localparam int BASE_TERM_W = CHAN_W + FRAC_BITS + 2;
   localparam int SCALED_W =
      ((CH_PROD_W > BASE_TERM_W) ? CH_PROD_W : BASE_TERM_W) + 1;
   localparam int CMP_W = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;

endpackage

### rtl/lgs_channel.sv
module lgs_channel
   import lgs_pkg::*;
(
   input  logic                     clock,
   input  logic signed [DIST_W-1:0] dist2,
   input  logic [CHAN_W-1:0]        base_chan,
   input  logic [CHAN_W-1:0]        delta_chan,
   output logic [CHAN_W-1:0]        chan_out
);

   logic signed [CH_PROD_W-1:0] prod_in, prod_ff;
   logic [CHAN_W-1:0]           base_in, base_ff;
   logic signed [SCALED_W-1:0]  scaled;
   logic                        over;
   logic [CHAN_W-1:0]           chan_in, chan_ff;

   assign prod_in = CH_PROD_W'(dist2) * CH_PROD_W'($signed({1'b0, delta_chan}));
   assign base_in = base_chan;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   assign scaled = (SCALED_W'($signed({1'b0, base_ff})) <<< (FRAC_BITS + 1))
                 + SCALED_W'(prod_ff);

   // floor of the value, zero when negative, saturated at the channel maximum
   assign over = |scaled[SCALED_W-2:FRAC_BITS+1+CHAN_W];

   always_comb begin
      if (scaled[SCALED_W-1]) begin
         chan_in = '0;
      end else if (over) begin
         chan_in = '1;
      end else begin
         chan_in = scaled[FRAC_BITS+CHAN_W:FRAC_BITS+1];
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
   end

   assign chan_out = chan_ff;

endmodule

### rtl/linear_gradient_shader.sv
// Linear gradient shader, five-stage pipeline.
// An item taken at a clock edge moves through the stage registers to the rsp_ ports,
// where the receiver takes it; results are never held back.
// Throughput: one item per clock; busy stays low, start may be high every cycle.
// Stages: offsets and clip test, two 14x24 products, distance sum, channel products, clamp.
// Reset clears all stage valid bits and every config register to zero.
module linear_gradient_shader
   import lgs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_pixel_x,
   input  logic signed [COORD_BITS-1:0] req_pixel_y,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [CHAN_W-1:0]            rsp_red,
   output logic [CHAN_W-1:0]            rsp_green,
   output logic [CHAN_W-1:0]            rsp_blue,
   output logic                         rsp_visible,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int NSTAGE = 5;

   logic signed [CENTER_W-1:0] center_x_ff, center_y_ff;
   logic signed [GRAD_W-1:0]   grad_x_ff, grad_y_ff;
   logic [COLOR_W-1:0]         base_ff, delta_ff;
   logic [FRAME_W-1:0]         frame_w_ff, frame_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         grad_x_ff   <= '0;
         grad_y_ff   <= '0;
         base_ff     <= '0;
         delta_ff    <= '0;
         frame_w_ff  <= '0;
         frame_h_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[CENTER_W-1:0];
            CSR_GRAD_X:   grad_x_ff   <= csr_wdata[GRAD_W-1:0];
            CSR_GRAD_Y:   grad_y_ff   <= csr_wdata[GRAD_W-1:0];
            CSR_BASE:     base_ff     <= csr_wdata[COLOR_W-1:0];
            CSR_DELTA:    delta_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_FRAME_W:  frame_w_ff  <= csr_wdata[FRAME_W-1:0];
            CSR_FRAME_H:  frame_h_ff  <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // valid bits, one per stage
   logic [NSTAGE-1:0] valid_in, valid_ff;
   assign valid_in = {valid_ff[NSTAGE-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // coordinates ride along with the item
   logic signed [COORD_BITS-1:0] x_ff [NSTAGE];
   logic signed [COORD_BITS-1:0] y_ff [NSTAGE];
   logic                         vis_ff [NSTAGE];
   logic                         vis_in;

   always_comb begin
      vis_in = !req_pixel_x[COORD_BITS-1] && !req_pixel_y[COORD_BITS-1]
             && (CMP_W'($unsigned(req_pixel_x)) < CMP_W'(frame_w_ff))
             && (CMP_W'($unsigned(req_pixel_y)) < CMP_W'(frame_h_ff));
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= req_pixel_x;
      y_ff[0]   <= req_pixel_y;
      vis_ff[0] <= vis_in;
      for (int i = 1; i < NSTAGE; i++) begin
         x_ff[i]   <= x_ff[i-1];
         y_ff[i]   <= y_ff[i-1];
         vis_ff[i] <= vis_ff[i-1];
      end
   end

   // stage 1: offsets from the center in half pixels
   logic signed [DX_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   assign dx_in = (DX_W'(req_pixel_x) <<< 1) - DX_W'(center_x_ff);
   assign dy_in = (DX_W'(req_pixel_y) <<< 1) - DX_W'(center_y_ff);

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   // stage 2: gradient products
   logic signed [PROD_W-1:0] px_in, py_in, px_ff, py_ff;
   assign px_in = PROD_W'(dx_ff) * PROD_W'(grad_x_ff);
   assign py_in = PROD_W'(dy_ff) * PROD_W'(grad_y_ff);

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   // stage 3: twice the distance
   logic signed [DIST_W-1:0] dist_in, dist_ff;
   assign dist_in = DIST_W'(px_ff) + DIST_W'(py_ff);

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   // stages 4 and 5 live in the channel units
   lgs_channel u_red (
      .clock      (clock),
      .dist2      (dist_ff),
      .base_chan  (base_ff[23:16]),
      .delta_chan (delta_ff[23:16]),
      .chan_out   (rsp_red)
   );

   lgs_channel u_green (
      .clock      (clock),
      .dist2      (dist_ff),
      .base_chan  (base_ff[15:8]),
      .delta_chan (delta_ff[15:8]),
      .chan_out   (rsp_green)
   );

   lgs_channel u_blue (
      .clock      (clock),
      .dist2      (dist_ff),
      .base_chan  (base_ff[7:0]),
      .delta_chan (delta_ff[7:0]),
      .chan_out   (rsp_blue)
   );

   assign rsp_valid   = valid_ff[NSTAGE-1];
   assign rsp_out_x   = x_ff[NSTAGE-1];
   assign rsp_out_y   = y_ff[NSTAGE-1];
   assign rsp_visible = vis_ff[NSTAGE-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("item did not come out after five cycles");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a matching item");

   a_vis_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_visible) |-> (!rsp_out_x[COORD_BITS-1] && !rsp_out_y[COORD_BITS-1]))
      else $error("negative coordinate marked visible");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lgs_pkg::*;

   localparam int  RESET_CYCLES = 5;
   localparam int  IDLE_PCT = 32;
   localparam int  SETTLE_CYCLES = 10;
   localparam int  RANDOM_PHASES = 14;
   localparam int  ITEMS_PER_PHASE = 125;
   localparam int  BURST_PHASE = 5;
   localparam int  MAX_PRINTED = 40;
   localparam longint CHAN_TOP = (longint'(1) << CHAN_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_IDX_W'(8);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = CSR_IDX_W'(15);

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } pixel_t;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [CHAN_W-1:0]            red;
      logic [CHAN_W-1:0]            green;
      logic [CHAN_W-1:0]            blue;
      logic                         visible;
   } shaded_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [COORD_BITS-1:0] req_pixel_x = '0;
   logic signed [COORD_BITS-1:0] req_pixel_y = '0;
   logic                         rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_out_x;
   logic signed [COORD_BITS-1:0] rsp_out_y;
   logic [CHAN_W-1:0]            rsp_red;
   logic [CHAN_W-1:0]            rsp_green;
   logic [CHAN_W-1:0]            rsp_blue;
   logic                         rsp_visible;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // shadow copy of the gradient registers
   logic signed [CENTER_W-1:0] center_x2;
   logic signed [CENTER_W-1:0] center_y2;
   logic signed [GRAD_W-1:0]   slope_x;
   logic signed [GRAD_W-1:0]   slope_y;
   logic [COLOR_W-1:0]         base_rgb;
   logic [COLOR_W-1:0]         delta_rgb;
   logic [FRAME_W-1:0]         frame_w;
   logic [FRAME_W-1:0]         frame_h;

   pixel_t  pixels_to_send[$];
   shaded_t shaded_q[$];
   bit      no_idle = 1'b0;
   int      error_count = 0;
   int      pixels_shaded = 0;
   int      visible_seen = 0;
   int      settings_used = 0;

   linear_gradient_shader dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .rsp_valid   (rsp_valid),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_visible (rsp_visible),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout with %0d items outstanding", shaded_q.size());
      $display("testbench: errors");
      $finish;
   end

   // base + d*delta with d carried at FRAC_BITS+1 fraction bits, floored and clamped
   function automatic logic [CHAN_W-1:0] channel_level(logic [CHAN_W-1:0] base8,
                                                       logic [CHAN_W-1:0] delta8,
                                                       longint dist2);
      longint scaled;
      longint level;
      scaled = longint'(base8) * (longint'(1) << (FRAC_BITS + 1)) + dist2 * longint'(delta8);
      if (scaled < 0) return '0;
      level = scaled >>> (FRAC_BITS + 1);
      return (level > CHAN_TOP) ? CHAN_W'(CHAN_TOP) : level[CHAN_W-1:0];
   endfunction

   function automatic shaded_t shade_pixel(logic signed [COORD_BITS-1:0] x,
                                           logic signed [COORD_BITS-1:0] y);
      shaded_t s;
      longint  px;
      longint  py;
      longint  dist2;
      px = x;
      py = y;
      dist2 = (2 * px - longint'(center_x2)) * longint'(slope_x)
            + (2 * py - longint'(center_y2)) * longint'(slope_y);
      s.x = x;
      s.y = y;
      s.red = channel_level(base_rgb[23:16], delta_rgb[23:16], dist2);
      s.green = channel_level(base_rgb[15:8], delta_rgb[15:8], dist2);
      s.blue = channel_level(base_rgb[7:0], delta_rgb[7:0], dist2);
      s.visible = (px >= 0) && (py >= 0) && (px < longint'(frame_w))
               && (py < longint'(frame_h));
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (error_count < MAX_PRINTED)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // driver: present the oldest pending pixel, idling at random
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (pixels_to_send.size() != 0
                   && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
         start <= 1'b1;
         req_pixel_x <= pixels_to_send[0].x;
         req_pixel_y <= pixels_to_send[0].y;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check results, then record the item taken at this edge
   always @(posedge clock) begin
      shaded_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (shaded_q.size() == 0) begin
               report_mismatch("item with nothing pending, out_x", rsp_out_x, 0);
            end else begin
               want = shaded_q.pop_front();
               check_field("out_x", rsp_out_x, want.x);
               check_field("out_y", rsp_out_y, want.y);
               check_field("red", rsp_red, want.red);
               check_field("green", rsp_green, want.green);
               check_field("blue", rsp_blue, want.blue);
               check_field("visible", rsp_visible, want.visible);
               if (rsp_visible) visible_seen++;
            end
         end
         if (start && !busy) begin
            void'(pixels_to_send.pop_front());
            shaded_q.push_back(shade_pixel(req_pixel_x, req_pixel_y));
            pixels_shaded++;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CENTER_X: center_x2 = data[CENTER_W-1:0];
         CSR_CENTER_Y: center_y2 = data[CENTER_W-1:0];
         CSR_GRAD_X:   slope_x = data[GRAD_W-1:0];
         CSR_GRAD_Y:   slope_y = data[GRAD_W-1:0];
         CSR_BASE:     base_rgb = data[COLOR_W-1:0];
         CSR_DELTA:    delta_rgb = data[COLOR_W-1:0];
         CSR_FRAME_W:  frame_w = data[FRAME_W-1:0];
         CSR_FRAME_H:  frame_h = data[FRAME_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_all(int cx, int cy, int gx, int gy, int base, int delta,
                              int fw, int fh);
      write_reg(CSR_CENTER_X, CSR_DATA_W'(cx));
      write_reg(CSR_CENTER_Y, CSR_DATA_W'(cy));
      write_reg(CSR_GRAD_X, CSR_DATA_W'(gx));
      write_reg(CSR_GRAD_Y, CSR_DATA_W'(gy));
      write_reg(CSR_BASE, CSR_DATA_W'(base));
      write_reg(CSR_DELTA, CSR_DATA_W'(delta));
      write_reg(CSR_FRAME_W, CSR_DATA_W'(fw));
      write_reg(CSR_FRAME_H, CSR_DATA_W'(fh));
      // writes to unmapped indexes must leave the registers alone
      write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                CSR_DATA_W'($urandom()));
      settings_used++;
   endtask

   function automatic int pick_slope();
      case ($urandom_range(2))
         0: return int'($urandom_range(0, 511)) - 256;
         1: return int'($urandom_range(0, 131071)) - 65536;
         default: return int'($urandom());
      endcase
   endfunction

   function automatic int pick_frame();
      case ($urandom_range(2))
         0: return int'($urandom_range(0, 4096));
         1: return 4096;
         default: return int'($urandom_range(0, 8191));
      endcase
   endfunction

   task automatic add_pixel(int x, int y);
      pixel_t p;
      p.x = COORD_BITS'(x);
      p.y = COORD_BITS'(y);
      pixels_to_send.push_back(p);
   endtask

   // about half the items land inside the frame where the frame allows it
   task automatic add_random_pixels(int count);
      int lim_x;
      int lim_y;
      lim_x = (frame_w > 2048) ? 2048 : int'(frame_w);
      lim_y = (frame_h > 2048) ? 2048 : int'(frame_h);
      @(posedge clock);
      repeat (count) begin
         if ($urandom_range(1) == 0 && lim_x > 0 && lim_y > 0)
            add_pixel($urandom_range(0, lim_x - 1), $urandom_range(0, lim_y - 1));
         else
            add_pixel(int'($urandom()), int'($urandom()));
      end
   endtask

   task automatic wait_drained();
      while (pixels_to_send.size() != 0 || shaded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // whole-pixel center, unit and half slopes, coordinate extremes
      program_all(0, 0, 32'h0001_0000, -32768, 32'h80_8080, 32'h01_0203, 4096, 4096);
      @(posedge clock);
      add_pixel(0, 0);
      add_pixel(-2048, -2048);
      add_pixel(2047, 2047);
      add_pixel(-2048, 2047);
      add_pixel(2047, -2048);
      add_pixel(-1, -1);
      add_pixel(1, 0);
      add_pixel(0, 1);
      add_pixel(-1, 0);
      wait_drained();

      // half-pixel center, zero y slope, frame edges, clamping at both ends
      program_all(1, -1, 32'h0001_0000, 0, 32'h80_FF00, 32'h01_01FF, 100, 50);
      @(posedge clock);
      add_pixel(99, 49);
      add_pixel(100, 49);
      add_pixel(99, 50);
      add_pixel(0, 0);
      add_pixel(-1, 0);
      add_pixel(0, -1);
      add_pixel(50, 25);
      add_pixel(200, -200);
      add_pixel(-200, 200);
      add_pixel(2047, 0);
      add_pixel(-2048, 0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: program_all(-4096, 4095, 32'h80_0000, 32'h7F_FFFF, 0, 32'hFF_FFFF, 0, 4096);
            1: program_all(4095, -4096, 32'h7F_FFFF, 32'h80_0000, 32'hFF_FFFF, 0,
                           8191, 8191);
            2: program_all(int'($urandom()), int'($urandom()), 0, 0, int'($urandom()),
                           int'($urandom()), 4096, 0);
            default: program_all(int'($urandom()), int'($urandom()), pick_slope(),
                                 pick_slope(), int'($urandom()), int'($urandom()),
                                 pick_frame(), pick_frame());
         endcase
         no_idle = (phase == BURST_PHASE);
         add_random_pixels(ITEMS_PER_PHASE / 2);
         // sender holds off here until the pipeline is empty
         wait_drained();
         add_random_pixels(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
         wait_drained();
      end

      if (shaded_q.size() != 0) report_mismatch("items left pending", shaded_q.size(), 0);
      $display("summary: %0d pixels shaded under %0d register settings", pixels_shaded,
               settings_used);
      $display("summary: %0d inside the frame, %0d mismatches", visible_seen, error_count);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/lgs_pkg.sv
rtl/lgs_channel.sv
rtl/linear_gradient_shader.sv
tb/sv/testbench.sv
